// ----- rtl/fwlm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwlm_pkg: shared types and constants of the first window local minimum block
// Request payload structs, field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package fwlm_pkg;

  localparam int SAMPLE_BITS   = 30;
  localparam int INDEX_BITS    = 20;
  localparam int MAX_SPAN_DEF  = 7;
  localparam int SPAN_BITS     = 3;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_BEFORE_DAYS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_AFTER_DAYS  = 1'd1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   is_last;
  } fwlm_in_t;

  typedef struct packed {
    logic                  found;
    logic [INDEX_BITS-1:0] position;
  } fwlm_out_t;

endpackage

// ----- rtl/first_window_local_minimum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_window_local_minimum: first local minimum over a sliding window
// Reports the 1-based position of the first sample that is not greater than
// its before_days predecessors and its after_days successors in a stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (in_valid/in_ready, in_data) carry one sample and a last
//   marker. At most one result request per stream leaves on out_valid/
//   out_ready/out_data: found=1 with the position as soon as a candidate is
//   confirmed, or found=0 at the last sample when none qualified.
//   The configuration port (cfg_we, cfg_index, cfg_wdata) sets before_days
//   and after_days; write it only while the block is idle. Values above
//   MAX_SPAN act as MAX_SPAN.
//   Throughput: one sample per cycle while the receiver does not stall.
//   A result request is registered: its sample sits in the input
//   register, then the result register loads the request from it, and
//   the window compares sit in the one stage between them.
//   When the receiver stalls, the result register holds its request and the
//   input register fills; in_ready then drops until the result is taken.
//   Reset (rst_n low, synchronous) empties the window, clears the sample
//   count and the answered flag and sets both spans to zero. The block takes
//   samples from the first cycle after reset; no clearing pass is needed.
//   After each last sample the stream state clears for the next stream.
// ----------------------------------------------------------------------------
module first_window_local_minimum #(
  parameter int MAX_SPAN = fwlm_pkg::MAX_SPAN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  fwlm_pkg::fwlm_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fwlm_pkg::fwlm_out_t                out_data,
  input  logic                               cfg_we,
  input  logic [fwlm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [fwlm_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int SB = fwlm_pkg::SAMPLE_BITS;
  localparam int IB = fwlm_pkg::INDEX_BITS;
  localparam int SW = fwlm_pkg::SPAN_BITS;

  // configuration
  logic [SW-1:0] before_r, after_r;
  logic [SW-1:0] span_x, span_y;

  // input register
  logic               in_valid_r;
  fwlm_pkg::fwlm_in_t in_r;

  // window: entry 0 is the newest stored sample
  logic [SB-1:0]       win_r   [MAX_SPAN];
  logic [SB-1:0]       win_nxt [MAX_SPAN];
  logic [MAX_SPAN-1:0] vld_r, vld_nxt;
  logic [MAX_SPAN-1:0] mark_r, mark_nxt;
  logic [IB-1:0]       count_r, count_nxt;
  logic                answered_r, answered_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  fwlm_pkg::fwlm_out_t out_r, out_nxt;

  // window after the shift, the incoming sample at entry 0
  logic [SB-1:0]     sw      [MAX_SPAN+1];
  logic [MAX_SPAN:0] sv, sm, cand;
  logic              s2_go, before_ok, hit, emit;
  logic [SW+2:0]     sel;
  logic [IB-1:0]     count_inc;

  assign s2_go    = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || s2_go;

  // saturate the spans at the window size
  assign span_x = (before_r > MAX_SPAN) ? SW'(MAX_SPAN) : before_r;
  assign span_y = (after_r > MAX_SPAN) ? SW'(MAX_SPAN) : after_r;

  // count the sample, stopping at the top of the position range
  assign count_inc = (count_r == {IB{1'b1}}) ? count_r : count_r + IB'(1);

  always_comb begin
    sw[0] = in_r.sample;
    sv[0] = 1'b1;
    for (int k = 1; k <= MAX_SPAN; k++) begin
      sw[k] = win_r[k-1];
      sv[k] = vld_r[k-1];
      sm[k] = mark_r[k-1];
    end

    // before-condition of the new sample against up to span_x predecessors
    before_ok = 1'b1;
    for (int k = 1; k <= MAX_SPAN; k++) begin
      if (k <= span_x && sv[k] && (sw[0] > sw[k])) before_ok = 1'b0;
    end
    sm[0] = before_ok;

    // candidate of age d: marked and not greater than any newer sample
    for (int d = 0; d <= MAX_SPAN; d++) begin
      cand[d] = sv[d] && sm[d];
      for (int k = 0; k < d; k++) begin
        if (sv[k] && (sw[d] > sw[k])) cand[d] = 1'b0;
      end
    end

    // oldest qualifying age wins; only age span_y unless the stream ends
    hit = 1'b0;
    sel = '0;
    for (int d = 0; d <= MAX_SPAN; d++) begin
      if (cand[d] && d <= span_y && (in_r.is_last || d == span_y)) begin
        hit = 1'b1;
        sel = (SW+3)'(d);
      end
    end
  end

  assign emit = !answered_r && (hit || in_r.is_last);

  // next window, count and answered flag
  always_comb begin
    for (int k = 0; k < MAX_SPAN; k++) win_nxt[k] = win_r[k];
    vld_nxt      = vld_r;
    mark_nxt     = mark_r;
    count_nxt    = count_r;
    answered_nxt = answered_r;
    if (s2_go) begin
      for (int k = 0; k < MAX_SPAN; k++) begin
        win_nxt[k]  = sw[k];
        vld_nxt[k]  = sv[k];
        mark_nxt[k] = sm[k];
      end
      count_nxt    = count_inc;
      answered_nxt = answered_r || hit;
      if (in_r.is_last) begin
        // drop the stream state for the next stream
        vld_nxt      = '0;
        mark_nxt     = '0;
        count_nxt    = '0;
        answered_nxt = 1'b0;
      end
    end
  end

  // next result request
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (s2_go && emit) begin
      out_valid_nxt = 1'b1;
      out_nxt.found = hit;
      if (!hit) begin
        out_nxt.position = '0;
      end else if (count_inc >= sel) begin
        out_nxt.position = count_inc - IB'(sel);
      end else begin
        out_nxt.position = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      before_r    <= '0;
      after_r     <= '0;
      in_valid_r  <= 1'b0;
      vld_r       <= '0;
      mark_r      <= '0;
      count_r     <= '0;
      answered_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          fwlm_pkg::CFG_BEFORE_DAYS: before_r <= cfg_wdata;
          fwlm_pkg::CFG_AFTER_DAYS:  after_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_ready) in_valid_r <= in_valid;
      vld_r       <= vld_nxt;
      mark_r      <= mark_nxt;
      count_r     <= count_nxt;
      answered_r  <= answered_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_r <= in_data;
    for (int k = 0; k < MAX_SPAN; k++) win_r[k] <= win_nxt[k];
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  // the input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready && in_valid_r))
    else $error("in_ready low without a stalled result");

  // a last sample leaves an empty stream behind
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_go && in_r.is_last) |=> (count_r == '0 && !answered_r && vld_r == '0))
    else $error("stream state not cleared after last sample");

  // found results carry a 1-based position, not-found results carry zero
  a_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.found ? (out_r.position != '0) : (out_r.position == '0)))
    else $error("result position inconsistent with found");

  // an answered stream raises no further result
  a_once: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_go && answered_r) |=> !out_valid_r)
    else $error("second result for one stream");
`endif

endmodule
